FILE: hw/rtl/usc_pkg.sv
package usc_pkg;

	// request kinds carried in s_tuser
	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_PUSH  = 3'd1;
	localparam logic [2:0] REQ_POP   = 3'd2;
	localparam logic [2:0] REQ_CLEAR = 3'd3;
	localparam logic [2:0] REQ_QUERY = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_DUP   = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [15:0] COOL_LEN_RST = 16'd100;

	// per-cycle command broadcast to every slot cell
	typedef struct packed {
		logic push;   // take the neighbour nearer the top
		logic pop;    // take the neighbour further from the top
		logic clear;  // empty the slot
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/usc_cell.sv
module usc_cell #(
	parameter int ID_BITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  usc_pkg::cell_ctrl_t ctrl,
	input  logic [ID_BITS-1:0]  key,
	input  logic [ID_BITS-1:0]  prev_id,
	input  logic                prev_valid,
	input  logic [ID_BITS-1:0]  next_id,
	input  logic                next_valid,
	input  logic                found_in,
	output logic [ID_BITS-1:0]  id,
	output logic                valid,
	output logic                found_out
);

	logic [ID_BITS-1:0] id_q;
	logic               valid_q;
	logic               found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q    <= '0;
			valid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			// membership probe ripples one cell per cycle
			found_q <= found_in | (valid_q && (id_q == key));
			if (ctrl.clear) begin
				id_q    <= '0;
				valid_q <= 1'b0;
			end else if (ctrl.push) begin
				id_q    <= prev_id;
				valid_q <= prev_valid;
			end else if (ctrl.pop) begin
				id_q    <= next_id;
				valid_q <= next_valid;
			end
		end
	end

	assign id        = id_q;
	assign valid     = valid_q;
	assign found_out = found_q;

endmodule

FILE: hw/rtl/unique_stack_with_cooldown.sv
// a request beat is taken only in the idle state, then walked and applied; no new request is
// taken until the apply state, which waits for a free output register, is done; the walk lets
// the membership probe pass along the row of slot cells one cell per cycle
// a finished result may wait in the output register while the next request is walked
// reset (arst_n low, asynchronous): stack empty, cooldown idle, cooldown length 100
module unique_stack_with_cooldown #(
	parameter int STACK_SLOTS = 8,
	parameter int ID_BITS     = 4,
	localparam int CNT_W       = $clog2(STACK_SLOTS + 1),
	localparam int TDATA_IN_W  = ((ID_BITS + 7) / 8) * 8,
	localparam int OUT_W       = 2 + 2 * ID_BITS + CNT_W + 3,
	localparam int TDATA_OUT_W = ((OUT_W + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [TDATA_IN_W-1:0]        s_tdata,   // item_id, zero fill
	input  logic [2:0]                   s_tuser,   // req_type
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [TDATA_OUT_W-1:0]       m_tdata,   // status, popped_id, top_id,
	                                                // stack_depth, found_in_stack,
	                                                // cooling_down, restore_pulse, zero fill
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int WALK_W      = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;

	// sequencer codes
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0]         state_q;
	logic [WALK_W-1:0]  walk_q;
	logic [2:0]         req_q;
	logic [ID_BITS-1:0] key_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [15:0]        cool_q;
	logic [15:0]        cool_len_q;

	logic                   m_tvalid_q;
	logic [TDATA_OUT_W-1:0] m_tdata_q;

	// slot row: index 0 is the top of stack, index STACK_SLOTS is a blank end stop
	logic [ID_BITS-1:0] slot_id    [0:STACK_SLOTS];
	logic               slot_valid [0:STACK_SLOTS];
	logic               slot_found [0:STACK_SLOTS-1];

	usc_pkg::cell_ctrl_t ctrl;

	assign slot_id[STACK_SLOTS]    = '0;
	assign slot_valid[STACK_SLOTS] = 1'b0;

	for (genvar i = 0; i < STACK_SLOTS; i++) begin : g_slot
		usc_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key       (key_q),
			.prev_id   ((i == 0) ? key_q : slot_id[(i == 0) ? 0 : i - 1]),
			.prev_valid((i == 0) ? 1'b1 : slot_valid[(i == 0) ? 0 : i - 1]),
			.next_id   (slot_id[i + 1]),
			.next_valid(slot_valid[i + 1]),
			.found_in  ((i == 0) ? 1'b0 : slot_found[(i == 0) ? 0 : i - 1]),
			.id        (slot_id[i]),
			.valid     (slot_valid[i]),
			.found_out (slot_found[i])
		);
	end

	// handshakes
	logic accept;
	logic out_free;
	logic apply;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign apply    = (state_q == S_APPLY) && out_free;

	// request decode once the probe has reached the far end of the row
	logic               found;
	logic               is_full;
	logic               is_empty;
	logic [1:0]         status;
	logic [ID_BITS-1:0] popped;
	logic [ID_BITS-1:0] top_nx;
	logic [CNT_W-1:0]   cnt_nx;
	logic [15:0]        cool_nx;
	logic               pulse;

	assign found    = slot_found[STACK_SLOTS-1];
	assign is_full  = (cnt_q == CNT_W'(STACK_SLOTS));
	assign is_empty = (cnt_q == '0);

	always_comb begin
		ctrl    = '0;
		status  = usc_pkg::ST_OK;
		popped  = '0;
		top_nx  = is_empty ? '0 : slot_id[0];
		cnt_nx  = cnt_q;
		cool_nx = cool_q;
		pulse   = 1'b0;
		case (req_q)
			usc_pkg::REQ_TICK: begin
				if (cool_q != '0) cool_nx = cool_q - 16'd1;
			end
			usc_pkg::REQ_PUSH: begin
				// a full stack refuses before the duplicate check
				if (is_full) begin
					status = usc_pkg::ST_FULL;
				end else if (found) begin
					status = usc_pkg::ST_DUP;
				end else begin
					ctrl.push = 1'b1;
					cnt_nx    = cnt_q + CNT_W'(1);
					top_nx    = key_q;
					cool_nx   = cool_len_q;
				end
			end
			usc_pkg::REQ_POP: begin
				if (is_empty) begin
					status = usc_pkg::ST_EMPTY;
				end else begin
					ctrl.pop = 1'b1;
					popped   = slot_id[0];
					cnt_nx   = cnt_q - CNT_W'(1);
					top_nx   = slot_id[1];
					cool_nx  = cool_len_q;
					pulse    = (cnt_q == CNT_W'(1));
				end
			end
			usc_pkg::REQ_CLEAR: begin
				// reloads and pulses even on an empty stack
				ctrl.clear = 1'b1;
				cnt_nx     = '0;
				top_nx     = '0;
				cool_nx    = cool_len_q;
				pulse      = 1'b1;
			end
			default: begin
				// query and unused kinds only report
			end
		endcase
		if (!apply) ctrl = '0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			walk_q  <= '0;
			req_q   <= usc_pkg::REQ_TICK;
			key_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q   <= s_tuser;
						key_q   <= s_tdata[ID_BITS-1:0];
						walk_q  <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_q == WALK_W'(STACK_SLOTS - 1)) begin
						state_q <= S_APPLY;
					end else begin
						walk_q <= walk_q + WALK_W'(1);
					end
				end
				S_APPLY: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// depth and cooldown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			cool_q <= '0;
		end else if (apply) begin
			cnt_q  <= cnt_nx;
			cool_q <= cool_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (apply) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			m_tdata_q <= TDATA_OUT_W'({pulse, (cool_nx != '0), found, cnt_nx,
				top_nx, popped, status});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// register port: cooldown length at byte address 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cool_len_q <= usc_pkg::COOL_LEN_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			cool_len_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, cool_len_q} : 32'd0;

endmodule

FILE: tb/usc_checker.sv
`timescale 1ns / 1ps

module usc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // item_id, zero fill
	input  logic [2:0]  s_tuser,   // req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // status, popped_id, top_id, stack_depth,
	                               // found_in_stack, cooling_down, restore_pulse, zero fill
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          n_fail,
	output int          n_pending,
	output int          n_checked
);

	localparam int SLOTS = 8;
	localparam logic [2:0] ADDR_COOL_LEN = 3'd0;

	typedef struct {
		logic [1:0] status;
		logic [3:0] popped;
		logic [3:0] top;
		logic [3:0] depth;
		logic       found;
		logic       cooling;
		logic       restore;
	} stack_result_t;

	// shadow of the block's state
	logic [3:0]    slot_id [SLOTS];
	logic [3:0]    depth;
	logic [15:0]   cool_left;
	logic [15:0]   cool_len;
	stack_result_t result_q [$];

	task automatic report(input string msg);
		if (n_fail < 50)
			$display("[%0t] mismatch: %s", $time, msg);
		n_fail++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// applies one request to the shadow state and returns the result it causes
	function automatic stack_result_t step_stack(input logic [2:0] kind, input logic [3:0] id);
		stack_result_t r;
		logic          hit;
		hit = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			if (i < depth && slot_id[i] == id)
				hit = 1'b1;
		r.status  = usc_pkg::ST_OK;
		r.popped  = '0;
		r.restore = 1'b0;
		r.found   = hit;
		case (kind)
			usc_pkg::REQ_TICK: begin
				if (cool_left != 0)
					cool_left--;
			end
			usc_pkg::REQ_PUSH: begin
				if (depth >= SLOTS) begin
					r.status = usc_pkg::ST_FULL;
				end else if (hit) begin
					r.status = usc_pkg::ST_DUP;
				end else begin
					slot_id[depth] = id;
					depth++;
					cool_left = cool_len;
				end
			end
			usc_pkg::REQ_POP: begin
				if (depth == 0) begin
					r.status = usc_pkg::ST_EMPTY;
				end else begin
					depth--;
					r.popped = slot_id[depth];
					slot_id[depth] = '0;
					cool_left = cool_len;
					r.restore = (depth == 0);
				end
			end
			usc_pkg::REQ_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					slot_id[i] = '0;
				depth = '0;
				cool_left = cool_len;
				r.restore = 1'b1;
			end
			default: ;
		endcase
		r.top     = (depth != 0) ? slot_id[depth - 4'd1] : 4'd0;
		r.depth   = depth;
		r.cooling = (cool_left != 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_id[i] = '0;
			depth = '0;
			cool_left = '0;
			cool_len = usc_pkg::COOL_LEN_RST;
			result_q.delete();
			n_fail = 0;
			n_checked = 0;
			n_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_checked++;
				if (result_q.size() == 0) begin
					report($sformatf("result beat 0x%06h with nothing expected", m_tdata));
				end else begin
					want = result_q.pop_front();
					check_field("status", m_tdata[1:0], want.status);
					check_field("popped_id", m_tdata[5:2], want.popped);
					check_field("top_id", m_tdata[9:6], want.top);
					check_field("stack_depth", m_tdata[13:10], want.depth);
					check_field("found_in_stack", m_tdata[14], want.found);
					check_field("cooling_down", m_tdata[15], want.cooling);
					check_field("restore_pulse", m_tdata[16], want.restore);
				end
			end
			if (psel && penable && pready && paddr == ADDR_COOL_LEN) begin
				if (pwrite)
					cool_len = pwdata[15:0];
				else if (prdata != {16'h0000, cool_len})
					report($sformatf("cooldown length read 0x%08h, expected 0x%08h",
						prdata, {16'h0000, cool_len}));
			end
			if (s_tvalid && s_tready)
				result_q.push_back(step_stack(s_tuser, s_tdata[3:0]));
			n_pending <= result_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam logic [2:0] ADDR_COOL_LEN = 3'd0;
	// delay from a request beat to the offer of its result beat, used in the drain wait
	localparam int LATENCY = 9;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // item_id, zero fill
	logic [2:0]  s_tuser;   // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // status, popped_id, top_id, stack_depth,
	                        // found_in_stack, cooling_down, restore_pulse, zero fill
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int n_fail;
	int n_pending;
	int n_checked;

	bit idle_on;        // random idling on both sides while set
	int stall_left;     // remaining cycles of the current receiver stall
	int sent_by_kind [8];
	int n_settings;

	unique_stack_with_cooldown dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// watches both streams and the register port, predicts and compares
	usc_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.n_fail    (n_fail),
		.n_pending (n_pending),
		.n_checked (n_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop: 2 ms leaves a wide margin for roughly 450 requests
	// and for the idle waits between phases
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver side: random stall bursts, none once idle_on drops
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// two-phase register access; the access beat lands when pready is high
	task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// sender drops valid and holds off until every outstanding result has been taken
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// reconfigure only with the block drained, then read the value back
	task automatic set_cool_len(input logic [15:0] ticks);
		wait_idle();
		apb_access(1'b1, ADDR_COOL_LEN, {16'h0000, ticks});
		apb_access(1'b0, ADDR_COOL_LEN, 32'h0);
		n_settings++;
	endtask

	// one request beat; valid only drops when a gap is taken before it
	task automatic send(input logic [2:0] kind, input logic [3:0] id);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'h0, id};
		do @(posedge clk); while (!s_tready);
		sent_by_kind[kind]++;
	endtask

	// push-heavy mix so the stack fills and refusals and duplicates turn up,
	// with ticks to walk the countdown and the odd pop-all to start over
	task automatic run_random(input int n);
		int          pick;
		logic [2:0]  kind;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 28)
				kind = usc_pkg::REQ_TICK;
			else if (pick < 58)
				kind = usc_pkg::REQ_PUSH;
			else if (pick < 73)
				kind = usc_pkg::REQ_POP;
			else if (pick < 77)
				kind = usc_pkg::REQ_CLEAR;
			else if (pick < 92)
				kind = usc_pkg::REQ_QUERY;
			else
				kind = 3'(usc_pkg::REQ_QUERY + $urandom_range(1, 3));   // unused codes
			send(kind, 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		// every input known from time zero
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = usc_pkg::REQ_TICK;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_on  = 1'b1;
		stall_left = 0;
		n_settings = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the cooldown length read back
		apb_access(1'b0, ADDR_COOL_LEN, 32'h0);

		// directed: empty-stack corners first, with the reset cooldown length
		send(usc_pkg::REQ_QUERY, 4'd0);
		send(usc_pkg::REQ_POP, 4'd5);        // pop on empty
		send(usc_pkg::REQ_TICK, 4'd0);       // tick with the countdown at zero
		send(usc_pkg::REQ_CLEAR, 4'd0);      // pop-all on empty still reloads and pulses
		send(usc_pkg::REQ_PUSH, 4'd15);
		send(usc_pkg::REQ_PUSH, 4'd0);
		send(usc_pkg::REQ_PUSH, 4'd15);      // duplicate
		send(usc_pkg::REQ_QUERY, 4'd15);
		send(usc_pkg::REQ_TICK, 4'd0);
		send(usc_pkg::REQ_POP, 4'd0);
		// fill to the brim
		for (int k = 1; k < 8; k++)
			send(usc_pkg::REQ_PUSH, 4'(k));
		send(usc_pkg::REQ_PUSH, 4'd3);       // full and duplicate: full wins
		send(usc_pkg::REQ_PUSH, 4'd9);       // full
		for (int k = 1; k < 4; k++)
			send(3'(usc_pkg::REQ_QUERY + k), 4'd15);
		send(usc_pkg::REQ_POP, 4'd0);
		send(usc_pkg::REQ_CLEAR, 4'd0);

		// shortest nonzero cooldown: see it expire and restart
		set_cool_len(16'd1);
		send(usc_pkg::REQ_PUSH, 4'd10);
		send(usc_pkg::REQ_TICK, 4'd0);
		send(usc_pkg::REQ_POP, 4'd0);        // empties the stack
		send(usc_pkg::REQ_TICK, 4'd0);

		// random phases over several cooldown lengths, extremes included
		set_cool_len(16'd3);
		run_random(50);
		wait_idle();                // sender pause mid-phase
		run_random(50);
		set_cool_len(16'hFFFF);
		run_random(90);
		set_cool_len(16'd0);
		run_random(90);

		// last stretch runs flat out on both sides
		idle_on = 1'b0;
		set_cool_len(16'($urandom_range(2, 12)));
		run_random(100);

		wait_idle();
		$display("requests sent: tick %0d, push %0d, pop %0d, pop-all %0d, query %0d, unused %0d",
			sent_by_kind[usc_pkg::REQ_TICK], sent_by_kind[usc_pkg::REQ_PUSH],
			sent_by_kind[usc_pkg::REQ_POP], sent_by_kind[usc_pkg::REQ_CLEAR],
			sent_by_kind[usc_pkg::REQ_QUERY],
			sent_by_kind[5] + sent_by_kind[6] + sent_by_kind[7]);
		$display("%0d result beats checked over %0d cooldown lengths incl. 0 and 65535",
			n_checked, n_settings);
		if (n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
